>>> design/rsm_pkg.sv
// ============================================================================
// rsm_pkg - ring slot manager shared definitions
// Operation codes, controller states, command and status bundles and the
// fixed field widths used by the interfaces, controller and datapath.
// ============================================================================
package rsm_pkg;

    // Fixed field widths of the transaction payloads
    localparam int OP_W  = 3;
    localparam int CNT_W = 16;
    localparam int IDX_W = 4;
    localparam int BLK_W = 32;

    // Default sizing of the ring
    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 64;

    // Largest positive blocked count
    localparam logic signed [BLK_W-1:0] BLK_MAX = 32'sh7FFF_FFFF;

    // Division of the count by WIDTH: quotient step, then remainder step
    localparam int DIV_STEPS = 2;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 3'd0,
        OP_RESERVE   = 3'd1,
        OP_COMMIT    = 3'd2,
        OP_READ      = 3'd3,
        OP_RELEASE   = 3'd4,
        OP_REL_COUNT = 3'd5
    } rsm_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DIVIDE,
        ST_STEP,
        ST_REMAIN,
        ST_REPORT
    } rsm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch the incoming operation
        logic apply;      // execute an operation other than release by count
        logic div_step;   // one division step
        logic zero_blk;   // release by count with nothing to release
        logic step;       // release one slot
        logic remain;     // apply the remainder rule
        logic load_out;   // capture the result into the output register
    } rsm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_rel_count;  // incoming operation is release by count
        logic div_last;       // final division step this cycle
        logic zero_case;      // count or blocked total not positive
        logic step_done;      // quotient exhausted or release caught the reader
    } rsm_status_t;

endpackage

>>> design/rsm_ifs.sv
// ============================================================================
// rsm_ifs - ring slot manager channel interfaces
// Request channel (operation and count) and result channel (grant, pointers
// and blocked count), each a valid/ready pair with its payload.
// ============================================================================
interface rsm_req_if;
    import rsm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [CNT_W-1:0] unit_count;

    modport source (output valid, output operation, output unit_count, input ready);
    modport sink   (input valid, input operation, input unit_count, output ready);
endinterface

interface rsm_rsp_if;
    import rsm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    granted;
    logic [IDX_W-1:0]        slot_index;
    logic                    is_empty;
    logic                    is_full;
    logic [IDX_W-1:0]        write_index;
    logic [IDX_W-1:0]        read_index;
    logic [IDX_W-1:0]        busy_index;
    logic signed [BLK_W-1:0] blocked_units;

    modport source (
        output valid, output granted, output slot_index, output is_empty,
        output is_full, output write_index, output read_index, output busy_index,
        output blocked_units, input ready
    );
    modport sink (
        input valid, input granted, input slot_index, input is_empty,
        input is_full, input write_index, input read_index, input busy_index,
        input blocked_units, output ready
    );
endinterface

>>> design/rsm_ctrl.sv
// ============================================================================
// rsm_ctrl - ring slot manager controller
// Sequences each transaction through apply, or division, slot release and
// remainder steps, and owns the result valid flag.
// ============================================================================
module rsm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsm_pkg::rsm_cmd_t    cmd,
    input  rsm_pkg::rsm_status_t st
);
    import rsm_pkg::*;

    rsm_state_t state_reg;
    rsm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // Output register can take a result when empty or draining this cycle
    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = st.req_rel_count ? ST_DIVIDE : ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (st.div_last)
                begin
                    state_next = st.zero_case ? ST_REPORT : ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (st.step_done)
                begin
                    state_next = ST_REMAIN;
                end
            end
            ST_REMAIN:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ST_APPLY:
            begin
                cmd.apply    = slot_free;
                cmd.load_out = slot_free;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cmd.zero_blk = st.div_last && st.zero_case;
            end
            ST_STEP:
            begin
                cmd.step = !st.step_done;
            end
            ST_REMAIN:
            begin
                cmd.remain = 1'b1;
            end
            ST_REPORT:
            begin
                cmd.load_out = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

>>> design/rsm_dpath.sv
// ============================================================================
// rsm_dpath - ring slot manager datapath
// Pointers, saturating blocked count with its residue modulo WIDTH, a
// reciprocal divider for release by count, and the result register.
// ============================================================================
module rsm_dpath #(
    parameter int DEPTH = rsm_pkg::DEPTH_DEF,
    parameter int WIDTH = rsm_pkg::WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rsm_pkg::rsm_cmd_t                      cmd,
    output rsm_pkg::rsm_status_t                   st,
    input  logic [rsm_pkg::OP_W-1:0]               operation,
    input  logic signed [rsm_pkg::CNT_W-1:0]       unit_count,
    output logic                                   granted,
    output logic [rsm_pkg::IDX_W-1:0]              slot_index,
    output logic                                   is_empty,
    output logic                                   is_full,
    output logic [rsm_pkg::IDX_W-1:0]              write_index,
    output logic [rsm_pkg::IDX_W-1:0]              read_index,
    output logic [rsm_pkg::IDX_W-1:0]              busy_index,
    output logic signed [rsm_pkg::BLK_W-1:0]       blocked_units
);
    import rsm_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int RW  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int QW  = CNT_W - 1;
    localparam int LW  = $clog2(WIDTH);
    localparam int SH  = QW + LW;
    localparam int MW  = QW + 1;
    localparam int PRW = QW + MW;
    localparam logic [PW-1:0]             PTR_LAST = PW'(DEPTH - 1);
    localparam logic signed [BLK_W:0]     WIDTH_X  = (BLK_W+1)'(WIDTH);
    localparam logic signed [BLK_W:0]     MAX_X    = (BLK_W+1)'(BLK_MAX);
    localparam logic [RW:0]               WIDTH_R  = (RW+1)'(WIDTH);
    localparam logic [RW-1:0]             MAX_RES  = RW'(BLK_MAX % WIDTH);
    localparam logic [MW-1:0]             RECIP    = MW'((2**SH + WIDTH - 1) / WIDTH);

    // Architectural state
    logic [PW-1:0]           wr_reg,  wr_next;
    logic [PW-1:0]           rd_reg,  rd_next;
    logic [PW-1:0]           rel_reg, rel_next;
    logic signed [BLK_W-1:0] blk_reg, blk_next;
    logic [RW-1:0]           res_reg, res_next;   // blocked count modulo WIDTH

    // Operation in flight and divider
    rsm_op_t                 op_reg;
    logic signed [CNT_W-1:0] cnt_reg;
    logic [QW-1:0]           quot_reg;
    logic [RW-1:0]           rem_reg;
    logic [DIV_CW-1:0]       div_cnt_reg;

    // Result register
    logic                    granted_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic                    empty_reg;
    logic                    full_reg;
    logic [IDX_W-1:0]        wr_idx_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [IDX_W-1:0]        rel_idx_reg;
    logic signed [BLK_W-1:0] blk_out_reg;

    logic                    grant;
    logic [PW-1:0]           slot;
    logic [PW-1:0]           wr_inc, rd_inc, rel_inc, wr_next_inc;
    logic signed [BLK_W:0]   blk_plus, blk_minus;
    logic signed [BLK_W-1:0] blk_rem;
    logic [RW:0]             res_wrap;
    logic [PRW-1:0]          recip_prod;
    logic [QW-1:0]           quot_calc;
    logic [QW-1:0]           quot_units;
    logic [RW-1:0]           rem_calc;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign wr_inc      = ptr_inc(wr_reg);
    assign rd_inc      = ptr_inc(rd_reg);
    assign rel_inc     = ptr_inc(rel_reg);
    assign wr_next_inc = ptr_inc(wr_next);

    assign blk_plus  = (BLK_W+1)'(blk_reg) + WIDTH_X;
    assign blk_minus = (BLK_W+1)'(blk_reg) - WIDTH_X;
    assign blk_rem   = blk_reg - BLK_W'(rem_reg);

    // Residue after subtracting the remainder, wrapped back into range
    assign res_wrap = (res_reg >= rem_reg)
                    ? (RW+1)'(res_reg) - (RW+1)'(rem_reg)
                    : (RW+1)'(res_reg) + WIDTH_R - (RW+1)'(rem_reg);

    // Quotient by reciprocal multiplication, exact for every count magnitude
    assign recip_prod = PRW'(cnt_reg[QW-1:0]) * PRW'(RECIP);
    assign quot_calc  = QW'(recip_prod >> SH);

    // Remainder from the registered quotient on the following cycle
    assign quot_units = QW'(PRW'(quot_reg) * PRW'(WIDTH));
    assign rem_calc   = RW'(cnt_reg[QW-1:0] - quot_units);

    always_comb
    begin
        st.req_rel_count = (rsm_op_t'(operation) == OP_REL_COUNT);
        st.div_last      = (div_cnt_reg == DIV_CW'(DIV_STEPS - 1));
        st.zero_case     = cnt_reg[CNT_W-1] || (cnt_reg == '0)
                        || blk_reg[BLK_W-1] || (blk_reg == '0);
        st.step_done     = (quot_reg == '0) || (rel_reg == rd_reg);
    end

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        rel_next = rel_reg;
        blk_next = blk_reg;
        res_next = res_reg;
        grant    = 1'b0;
        slot     = '0;

        if (cmd.apply)
        begin
            unique case (op_reg)
                OP_CLEAR:
                begin
                    wr_next  = '0;
                    rd_next  = '0;
                    rel_next = '0;
                    blk_next = '0;
                    res_next = '0;
                end
                OP_RESERVE:
                begin
                    if (wr_inc != rel_reg)
                    begin
                        grant = 1'b1;
                        slot  = wr_reg;
                    end
                end
                OP_COMMIT:
                begin
                    if (wr_inc != rel_reg)
                    begin
                        grant   = 1'b1;
                        slot    = wr_reg;
                        wr_next = wr_inc;
                    end
                end
                OP_READ:
                begin
                    if (rd_reg != wr_reg)
                    begin
                        grant   = 1'b1;
                        slot    = rd_reg;
                        rd_next = rd_inc;
                        if (blk_plus > MAX_X)
                        begin
                            blk_next = BLK_MAX;
                            res_next = MAX_RES;
                        end
                        else
                        begin
                            blk_next = BLK_W'(blk_plus);
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (rel_reg != rd_reg)
                    begin
                        rel_next = rel_inc;
                        if (blk_minus[BLK_W])
                        begin
                            blk_next = '0;
                            res_next = '0;
                        end
                        else
                        begin
                            blk_next = BLK_W'(blk_minus);
                        end
                    end
                end
                default:
                begin
                    grant = 1'b0;
                end
            endcase
        end

        if (cmd.zero_blk)
        begin
            blk_next = '0;
            res_next = '0;
        end

        if (cmd.step)
        begin
            rel_next = rel_inc;
            if (blk_minus[BLK_W])
            begin
                blk_next = '0;
                res_next = '0;
            end
            else
            begin
                blk_next = BLK_W'(blk_minus);
            end
        end

        // Remainder rule: an extra slot goes when the count lines up with it
        if (cmd.remain)
        begin
            blk_next = blk_rem;
            res_next = RW'(res_wrap);
            if (!blk_reg[BLK_W-1] && (blk_reg != '0) && (res_reg == rem_reg)
                && (rel_reg != rd_reg))
            begin
                rel_next = rel_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg      <= '0;
            rd_reg      <= '0;
            rel_reg     <= '0;
            blk_reg     <= '0;
            res_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            rel_reg <= rel_next;
            blk_reg <= blk_next;
            res_reg <= res_next;
            if (cmd.accept)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= rsm_op_t'(operation);
            cnt_reg <= unit_count;
        end
        else if (cmd.div_step)
        begin
            if (div_cnt_reg == '0)
            begin
                quot_reg <= quot_calc;
            end
            else
            begin
                rem_reg <= rem_calc;
            end
        end
        else if (cmd.step)
        begin
            quot_reg <= quot_reg - 1'b1;
        end

        if (cmd.load_out)
        begin
            granted_reg <= grant;
            slot_reg    <= IDX_W'(slot);
            empty_reg   <= (wr_next == rd_next);
            full_reg    <= (wr_next_inc == rd_next);
            wr_idx_reg  <= IDX_W'(wr_next);
            rd_idx_reg  <= IDX_W'(rd_next);
            rel_idx_reg <= IDX_W'(rel_next);
            blk_out_reg <= blk_next;
        end
    end

    assign granted       = granted_reg;
    assign slot_index    = slot_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;
    assign write_index   = wr_idx_reg;
    assign read_index    = rd_idx_reg;
    assign busy_index    = rel_idx_reg;
    assign blocked_units = blk_out_reg;

endmodule

>>> design/ring_slot_manager_with_release.sv
// ============================================================================
// ring_slot_manager_with_release - ring slot manager top level
// Write, read and release pointers over a ring of DEPTH slots with a signed
// count of blocked units; one result transaction per request transaction.
// ============================================================================
// Each request yields exactly one result, taken into an output register.
// Clear, reserve, commit, read, release slot and unused codes pass through
// the accepting step and an apply step that executes the operation and
// loads the result. Release by count divides the count by WIDTH (quotient,
// then remainder), releases one slot per cycle until the quotient is used
// up or the reader is reached (k slots, k at most DEPTH-1), then takes a
// remainder step and a report step; it goes from the division straight to
// the report step when the count or the blocked total is not positive. A
// result held back by the receiver holds the apply or report step of the
// next request. The next request is accepted once the current one has
// reached the output register.
module ring_slot_manager_with_release #(
    parameter int DEPTH = rsm_pkg::DEPTH_DEF,
    parameter int WIDTH = rsm_pkg::WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rsm_req_if.sink    req,
    rsm_rsp_if.source  rsp
);
    import rsm_pkg::*;

    rsm_cmd_t    cmd;
    rsm_status_t st;

    rsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .st        (st)
    );

    rsm_dpath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .operation     (req.operation),
        .unit_count    (req.unit_count),
        .granted       (rsp.granted),
        .slot_index    (rsp.slot_index),
        .is_empty      (rsp.is_empty),
        .is_full       (rsp.is_full),
        .write_index   (rsp.write_index),
        .read_index    (rsp.read_index),
        .busy_index    (rsp.busy_index),
        .blocked_units (rsp.blocked_units)
    );

endmodule

>>> tb/sv/ring_slot_checker.sv
// ============================================================================
// ring_slot_checker - result checker for the ring slot manager
// Watches the request and result channels, keeps its own copy of the ring
// pointers and blocked count, and compares every result field by field.
// ============================================================================
module ring_slot_checker (
    input  logic clk,
    input  logic rst_n,
    rsm_req_if   req,
    rsm_rsp_if   rsp,
    output int   mismatches,
    output int   pending,
    output int   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    localparam int     RING_DEPTH = DEPTH_DEF;
    localparam int     SLOT_UNITS = WIDTH_DEF;
    localparam longint UNITS_MIN  = -longint'(BLK_MAX) - 1;
    localparam int     PRINT_CAP  = 30;

    typedef struct packed {
        logic                    granted;
        logic [IDX_W-1:0]        slot_index;
        logic                    is_empty;
        logic                    is_full;
        logic [IDX_W-1:0]        write_index;
        logic [IDX_W-1:0]        read_index;
        logic [IDX_W-1:0]        busy_index;
        logic signed [BLK_W-1:0] blocked_units;
    } slot_status_t;

    int                      wr_ptr;
    int                      rd_ptr;
    int                      rel_ptr;
    logic signed [BLK_W-1:0] units_held;
    slot_status_t            expected_status_q[$];

    function automatic logic signed [BLK_W-1:0] sat_units(longint v);
        if (v > longint'(BLK_MAX))
            return BLK_MAX;
        if (v < UNITS_MIN)
            return UNITS_MIN[BLK_W-1:0];
        return v[BLK_W-1:0];
    endfunction

    // Advance the ring by one operation and return the status it reports
    function automatic slot_status_t apply_ring_op(logic [OP_W-1:0] op,
                                                   logic signed [CNT_W-1:0] cnt);
        slot_status_t s;
        longint       c;
        longint       units;
        longint       n;
        longint       r;
        longint       span;
        longint       k;
        longint       diff;
        s = '0;
        c = cnt;
        case (op)
            OP_CLEAR:
            begin
                wr_ptr     = 0;
                rd_ptr     = 0;
                rel_ptr    = 0;
                units_held = '0;
            end
            OP_RESERVE:
            begin
                if ((wr_ptr + 1) % RING_DEPTH != rel_ptr)
                begin
                    s.granted    = 1'b1;
                    s.slot_index = wr_ptr[IDX_W-1:0];
                end
            end
            OP_COMMIT:
            begin
                if ((wr_ptr + 1) % RING_DEPTH != rel_ptr)
                begin
                    s.granted    = 1'b1;
                    s.slot_index = wr_ptr[IDX_W-1:0];
                    wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
                end
            end
            OP_READ:
            begin
                if (rd_ptr != wr_ptr)
                begin
                    s.granted    = 1'b1;
                    s.slot_index = rd_ptr[IDX_W-1:0];
                    rd_ptr       = (rd_ptr + 1) % RING_DEPTH;
                    units_held   = sat_units(longint'(units_held) + SLOT_UNITS);
                end
            end
            OP_RELEASE:
            begin
                if (rel_ptr != rd_ptr)
                begin
                    rel_ptr    = (rel_ptr + 1) % RING_DEPTH;
                    units      = longint'(units_held) - SLOT_UNITS;
                    units_held = (units < 0) ? '0 : units[BLK_W-1:0];
                end
            end
            OP_REL_COUNT:
            begin
                if (c <= 0 || units_held <= 0)
                    units_held = '0;
                else
                begin
                    units   = units_held;
                    n       = c / SLOT_UNITS;
                    r       = c % SLOT_UNITS;
                    span    = (rd_ptr + RING_DEPTH - rel_ptr) % RING_DEPTH;
                    k       = (n < span) ? n : span;
                    rel_ptr = int'((rel_ptr + k) % RING_DEPTH);
                    units   = units - k * SLOT_UNITS;
                    if (units < 0)
                        units = 0;
                    // remainder lands on a slot boundary: release one more slot
                    diff = units - r;
                    if (diff < 0)
                        diff = -diff;
                    if (diff % SLOT_UNITS == 0 && units > 0 && rel_ptr != rd_ptr)
                        rel_ptr = (rel_ptr + 1) % RING_DEPTH;
                    units      = units - r;
                    units_held = sat_units(units);
                end
            end
            default:
            begin
            end
        endcase
        s.is_empty      = (wr_ptr == rd_ptr);
        s.is_full       = ((wr_ptr + 1) % RING_DEPTH == rd_ptr);
        s.write_index   = wr_ptr[IDX_W-1:0];
        s.read_index    = rd_ptr[IDX_W-1:0];
        s.busy_index    = rel_ptr[IDX_W-1:0];
        s.blocked_units = units_held;
        return s;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $realtime, checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slot_status_t got;
        slot_status_t want;
        if (!rst_n)
        begin
            wr_ptr     = 0;
            rd_ptr     = 0;
            rel_ptr    = 0;
            units_held = '0;
            expected_status_q.delete();
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            // take the result first: the block never answers in the accepting cycle
            if (rsp.valid && rsp.ready)
            begin
                if (expected_status_q.size() == 0)
                    flag_mismatch("unrequested result transaction", 1, 0);
                else
                begin
                    want = expected_status_q.pop_front();
                    got  = '{rsp.granted, rsp.slot_index, rsp.is_empty, rsp.is_full,
                             rsp.write_index, rsp.read_index, rsp.busy_index,
                             rsp.blocked_units};
                    if (got.granted !== want.granted)
                        flag_mismatch("granted", got.granted, want.granted);
                    if (got.slot_index !== want.slot_index)
                        flag_mismatch("slot_index", got.slot_index, want.slot_index);
                    if (got.is_empty !== want.is_empty)
                        flag_mismatch("is_empty", got.is_empty, want.is_empty);
                    if (got.is_full !== want.is_full)
                        flag_mismatch("is_full", got.is_full, want.is_full);
                    if (got.write_index !== want.write_index)
                        flag_mismatch("write_index", got.write_index, want.write_index);
                    if (got.read_index !== want.read_index)
                        flag_mismatch("read_index", got.read_index, want.read_index);
                    if (got.busy_index !== want.busy_index)
                        flag_mismatch("busy_index", got.busy_index, want.busy_index);
                    if (got.blocked_units !== want.blocked_units)
                        flag_mismatch("blocked_units", got.blocked_units,
                                      want.blocked_units);
                    checked <= checked + 1;
                end
            end
            if (req.valid && req.ready)
                expected_status_q.push_back(apply_ring_op(req.operation, req.unit_count));
            pending <= expected_status_q.size();
        end
    end

endmodule

>>> tb/sv/ring_slot_manager_with_release_tb.sv
// ============================================================================
// ring_slot_manager_with_release_tb - testbench top for the ring slot manager
// Drives directed and random operation sequences with random idling on both
// channels, a long result back-pressure stretch and a full drain pause; the
// checker beside the block predicts and compares every result.
// ============================================================================
module ring_slot_manager_with_release_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    localparam int              RING_DEPTH  = DEPTH_DEF;
    localparam int              SLOT_UNITS  = WIDTH_DEF;
    localparam int              STALL_LIMIT = 2000;
    localparam int              LONG_HOLD   = 150;
    localparam int              TAIL_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_SPARE_6  = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7  = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   results_checked;
    int   items_sent;
    int   directed_items;
    int   quiet_cycles;
    int   op_hist[8];
    bit   tx_idle_on;
    bit   rx_idle_on;
    bit   long_hold_req;

    rsm_req_if req_ch();
    rsm_rsp_if rsp_ch();

    ring_slot_manager_with_release #(
        .DEPTH (RING_DEPTH),
        .WIDTH (SLOT_UNITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ring_slot_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (outstanding),
        .checked    (results_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: random stall bursts, plus one long hold on request
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (long_hold_req && !hold_done)
            begin
                hold_done     = 1'b1;
                hold_left     = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                hold_left     = $urandom_range(0, 12);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Mostly whole slots, often with a remainder, now and then anything at all
    function automatic logic signed [CNT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel) inside
            0:       return CNT_W'($urandom);
            1:       return {1'b1, 15'($urandom)};
            2:       return '0;
            [3:6]:   return CNT_W'($urandom_range(0, 17) * SLOT_UNITS);
            default: return CNT_W'($urandom_range(0, 17) * SLOT_UNITS
                                   + $urandom_range(1, SLOT_UNITS - 1));
        endcase
    endfunction

    task automatic issue_op(logic [OP_W-1:0] op, logic signed [CNT_W-1:0] cnt);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.unit_count <= cnt;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        items_sent++;
        op_hist[op]++;
    endtask

    // Stop offering and hold until every expected result has come back
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Well-formed fill, drain and release runs, with some noise and a rare clear
    task automatic run_random_mix(int n_items, bit allow_idle);
        int target;
        int kind;
        int m;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if (allow_idle)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            m    = $urandom_range(1, RING_DEPTH);
            if (kind < 30)
            begin
                repeat (m)
                begin
                    if ($urandom_range(0, 1))
                        issue_op(OP_RESERVE, pick_count());
                    issue_op(OP_COMMIT, pick_count());
                end
            end
            else if (kind < 55)
                repeat (m) issue_op(OP_READ, pick_count());
            else if (kind < 78)
                repeat (m / 2 + 1)
                    issue_op(($urandom_range(0, 2) == 0) ? OP_RELEASE : OP_REL_COUNT,
                             pick_count());
            else if (kind < 97)
                repeat (m / 3 + 1) issue_op(OP_W'($urandom_range(1, 7)), pick_count());
            else
                issue_op(OP_CLEAR, pick_count());
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_CLEAR;
        req_ch.unit_count <= '0;
        items_sent        = 0;
        tx_idle_on        = 1'b1;
        rx_idle_on        = 1'b1;
        long_hold_req     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty and idle corner cases
        issue_op(OP_CLEAR, 16'sh7FFF);
        issue_op(OP_RESERVE, 16'h8000);
        issue_op(OP_READ, 16'sh7FFF);
        issue_op(OP_RELEASE, 16'h8000);
        issue_op(OP_REL_COUNT, 16'sd100);
        issue_op(OP_SPARE_6, 16'hFFFF);
        issue_op(OP_SPARE_7, 16'h5555);
        repeat (4) issue_op(OP_COMMIT, 16'hAAAA);
        repeat (3) issue_op(OP_READ, '0);
        // whole slot with no remainder: the boundary rule releases one more
        issue_op(OP_REL_COUNT, 16'(SLOT_UNITS));
        issue_op(OP_REL_COUNT, '0);
        issue_op(OP_READ, '0);
        // largest count: release up to the reader, then go negative
        issue_op(OP_REL_COUNT, 16'sh7FFF);
        issue_op(OP_COMMIT, '0);
        issue_op(OP_READ, '0);
        // one unit left: remainder removes it exactly
        issue_op(OP_REL_COUNT, 16'sd1);
        issue_op(OP_RELEASE, '0);
        issue_op(OP_REL_COUNT, 16'h8000);
        issue_op(OP_REL_COUNT, 16'hFFFF);
        issue_op(OP_CLEAR, '0);
        directed_items = items_sent;

        run_random_mix(300, 1'b1);

        // hold results back while requests keep coming
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        run_random_mix(30, 1'b0);

        run_random_mix(300, 1'b1);

        // let everything drain before carrying on
        wait_until_drained();
        run_random_mix(220, 1'b1);

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_mix(150, 1'b0);

        req_ch.valid <= 1'b0;
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d operations (%0d directed), %0d results compared",
                 items_sent, directed_items, results_checked);
        $display("clear %0d reserve %0d commit %0d read %0d release %0d by-count %0d spare %0d",
                 op_hist[OP_CLEAR], op_hist[OP_RESERVE], op_hist[OP_COMMIT],
                 op_hist[OP_READ], op_hist[OP_RELEASE], op_hist[OP_REL_COUNT],
                 op_hist[OP_SPARE_6] + op_hist[OP_SPARE_7]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
